// File: hdl/vbd_pkg.sv
// Shared types, constants and helper functions for the vibration baseline detector.
`default_nettype none

package vbd_pkg;

   // sample geometry: three accel axes then three gyro axes
   localparam int AXES        = 6;
   localparam int AXIS_W      = $clog2(AXES);
   localparam int SAMPLE_W    = 16;
   localparam int BASE_W      = 16;   // baseline magnitude, 0..32768
   localparam int DEV_W       = 16;   // per-axis deviation, 0..32768
   localparam int SUM_W       = 18;   // six deviations, at most 196608
   localparam int SCORE_W     = 16;
   localparam int THRESH_W    = 16;

   // defaults
   localparam int CAL_SAMPLES_DEF = 10;
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(150);

   // floor(x / 6) for x below 2**SUM_W: x * ceil(2**(SUM_W+3) / 6) >> (SUM_W+3)
   localparam int DIV6_SHIFT = SUM_W + 3;
   localparam int DIV6_M_W   = SUM_W + 1;
   localparam logic [63:0] DIV6_M_64 = ((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6;
   localparam logic [DIV6_M_W-1:0] DIV6_M = DIV6_M_64[DIV6_M_W-1:0];

   // stream word packing
   localparam int REQ_DATA_W = AXES * SAMPLE_W;
   localparam int RSP_DATA_W = 24;   // vibration, motion_score, zero fill

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [AXES-1:0]       sample_vec_type;
   typedef logic [BASE_W-1:0]           base_mag_type;
   typedef base_mag_type [AXES-1:0]     base_vec_type;

   typedef struct packed {
      logic calibrating;   // next item goes into the baseline sums
      logic busy;          // baselines being divided out, hold the pipe
   } calib_status_type;

   typedef enum logic [0:0] {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // unsigned magnitude of a signed sample; -32768 maps to 32768
   function automatic logic [DEV_W-1:0] sample_mag(input sample_type s);
      logic [DEV_W-1:0] raw;
      raw = DEV_W'(s);
      return s[SAMPLE_W-1] ? (~raw + DEV_W'(1)) : raw;
   endfunction

   // floor divide of the deviation sum by six
   function automatic logic [SCORE_W-1:0] div_by_six(input logic [SUM_W-1:0] x);
      logic [SUM_W+DIV6_M_W-1:0] prod;
      prod = {{DIV6_M_W{1'b0}}, x} * {{SUM_W{1'b0}}, DIV6_M};
      return prod[DIV6_SHIFT +: SCORE_W];
   endfunction

endpackage

`default_nettype wire

// File: hdl/vbd_calib.sv
// Calibration sums, sample counter and the shared divider that forms the baselines.
`default_nettype none

module vbd_calib #(
   parameter int CAL_SAMPLES = vbd_pkg::CAL_SAMPLES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,      // an item leaves the input stage
   input  wire vbd_pkg::sample_vec_type   samples,
   output vbd_pkg::calib_status_type      status,
   output vbd_pkg::base_vec_type          baselines
);
   import vbd_pkg::*;

   localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
   localparam int ACC_W  = SAMPLE_W + CNT_W;
   localparam int MAG_W  = ACC_W - 1;
   localparam int SHIFT  = MAG_W + $clog2(CAL_SAMPLES);
   localparam int M_W    = MAG_W + 1;
   localparam int PROD_W = MAG_W + M_W;
   localparam logic [63:0] RECIP_64 =
      ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
   localparam logic [M_W-1:0]   RECIP    = RECIP_64[M_W-1:0];
   localparam logic [CNT_W-1:0] CAL_N    = CNT_W'(CAL_SAMPLES);
   localparam logic [CNT_W-1:0] LAST_CAL = CNT_W'(CAL_SAMPLES - 1);
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

   logic signed [ACC_W-1:0] acc_ff [AXES];
   logic signed [ACC_W-1:0] acc_in [AXES];
   logic [CNT_W-1:0]        count_ff, count_in;
   base_mag_type            base_ff [AXES];
   div_state_type           state_ff, state_in;
   logic [AXIS_W-1:0]       idx_ff, idx_in;
   logic [AXIS_W-1:0]       wb_idx_ff;
   logic                    prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0]       prod_ff;
   logic                    cal_active;
   logic                    cal_step;
   logic signed [ACC_W-1:0] acc_sel;
   logic [MAG_W-1:0]        acc_mag;

   assign cal_active = (count_ff < CAL_N);
   assign cal_step   = step && cal_active;

   // running sums and item count
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < AXES; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (cal_step) begin
         count_in = count_ff + CNT_W'(1);
         for (int i = 0; i < AXES; i++) begin
            acc_in[i] = acc_ff[i] +
               {{(ACC_W-SAMPLE_W){samples[i][SAMPLE_W-1]}}, samples[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < AXES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < AXES; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   // divider sequencer: one axis per cycle through the shared multiplier
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      prod_valid_in = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            idx_in = '0;
            if (cal_step && (count_ff == LAST_CAL)) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            prod_valid_in = 1'b1;
            idx_in        = idx_ff + AXIS_W'(1);
            if (idx_ff == LAST_AXIS) begin
               state_in = DIV_IDLE;
               idx_in   = '0;
            end
         end
         default: begin
            state_in = DIV_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= DIV_IDLE;
         idx_ff        <= '0;
         prod_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   // |sum| times the reciprocal; the quotient is floor(|sum| / N) = |trunc(sum / N)|
   assign acc_sel = acc_ff[idx_ff];
   assign acc_mag = acc_sel[ACC_W-1] ? MAG_W'(-acc_sel) : MAG_W'(acc_sel);

   always_ff @(posedge clock) begin
      prod_ff   <= {{M_W{1'b0}}, acc_mag} * {{MAG_W{1'b0}}, RECIP};
      wb_idx_ff <= idx_ff;
   end

   // baseline magnitudes, written back in the cycle after the multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            base_ff[i] <= '0;
         end
      end else if (prod_valid_ff) begin
         base_ff[wb_idx_ff] <= prod_ff[SHIFT +: BASE_W];
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         baselines[i] = base_ff[i];
      end
   end

   assign status.calibrating = cal_active;
   assign status.busy        = (state_ff != DIV_IDLE) || prod_valid_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAL_N)
      else $error("calibration count ran past the sample total");

   a_run_after_cal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (count_ff == CAL_N))
      else $error("divider running before calibration finished");

   a_no_step_busy: assert property (@(posedge clock) disable iff (reset)
      step |-> !status.busy)
      else $error("item stepped while baselines were being formed");

   a_wb_follows_run: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> $past(state_ff == DIV_RUN))
      else $error("baseline write without a multiply in flight");

endmodule

`default_nettype wire

// File: hdl/vbd_score.sv
// Per-axis deviation from baseline, six-way sum, average and threshold compare.
`default_nettype none

module vbd_score (
   input  wire vbd_pkg::sample_vec_type           samples,
   input  wire vbd_pkg::base_vec_type             baselines,
   input  wire logic [vbd_pkg::THRESH_W-1:0]      threshold,
   input  wire logic                              calibrating,
   output logic [vbd_pkg::SCORE_W-1:0]            score,
   output logic                                   vibration
);
   import vbd_pkg::*;

   logic [DEV_W-1:0]   s_mag [AXES];
   logic [DEV_W-1:0]   dev   [AXES];
   logic [SUM_W-1:0]   dev_sum;
   logic [SCORE_W-1:0] avg;

   // | |baseline| - |sample| | per axis
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s_mag[i] = sample_mag(samples[i]);
         dev[i]   = (baselines[i] >= s_mag[i]) ? (baselines[i] - s_mag[i])
                                               : (s_mag[i] - baselines[i]);
      end
   end

   // sum as a small tree
   assign dev_sum = (SUM_W'(dev[0]) + SUM_W'(dev[1]) + SUM_W'(dev[2])) +
                    (SUM_W'(dev[3]) + SUM_W'(dev[4]) + SUM_W'(dev[5]));

   assign avg = div_by_six(dev_sum);

   // calibration items report nothing
   assign score     = calibrating ? '0 : avg;
   assign vibration = !calibrating && (avg > threshold);

endmodule

`default_nettype wire

// File: hdl/vibration_baseline_detector.sv
// Vibration baseline detector: stream stages, threshold register and submodules.
//
// Usage:
//   req_* carries one six-axis sample per word (accel x/y/z, gyro x/y/z).
//   rsp_* returns one result word per sample: a calibrating flag in tuser,
//   the vibration flag and the motion score in tdata.
//   csr_* writes the vibration threshold; write it only while the block is
//   idle. csr_ready is always high.
//   Each accepted word is registered in the input stage, its result in
//   the output stage. One sample per cycle is taken while rsp_tready is
//   high and no baselines are being formed; a new word is taken while a
//   result waits. The first CAL_SAMPLES words build the baselines. After
//   the last of them the input stage holds while one shared multiplier
//   turns the six sums into baselines, writing back each product in turn.
//   Reset (synchronous) clears the sums, count, baselines and pipeline
//   and sets the threshold to 150; calibration starts over.
//   When rsp_tready is low the result holds, the input stage fills, and
//   req_tready drops until the result is taken.
`default_nettype none

module vibration_baseline_detector #(
   parameter int CAL_SAMPLES = vbd_pkg::CAL_SAMPLES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each, lowest first)
   input  wire logic [vbd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // vibration [0], motion_score [16:1], zero fill [23:17]
   output logic [vbd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // calibrating [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [vbd_pkg::THRESH_W-1:0]    csr_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready
);
   import vbd_pkg::*;

   localparam int PAD_W = RSP_DATA_W - SCORE_W - 1;

   logic                  in_valid_ff;
   sample_vec_type        in_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_cal_ff;
   logic                  rsp_vib_ff;
   logic [SCORE_W-1:0]    rsp_score_ff;
   logic [THRESH_W-1:0]   thresh_ff;
   logic                  advance;
   logic                  req_take;
   calib_status_type      cal_status;
   base_vec_type          baselines;
   logic [SCORE_W-1:0]    score;
   logic                  vibration;

   // an item moves to the output stage when that stage frees up and no baselines are being formed
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready) && !cal_status.busy;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // threshold register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_data;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= sample_vec_type'(req_tdata);
      end
   end

   vbd_calib #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_calib (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .samples   (in_data_ff),
      .status    (cal_status),
      .baselines (baselines)
   );

   vbd_score u_score (
      .samples     (in_data_ff),
      .baselines   (baselines),
      .threshold   (thresh_ff),
      .calibrating (cal_status.calibrating),
      .score       (score),
      .vibration   (vibration)
   );

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cal_ff   <= cal_status.calibrating;
         rsp_vib_ff   <= vibration;
         rsp_score_ff <= score;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cal_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_score_ff, rsp_vib_ff};

   // checks
   a_cal_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cal_ff) |-> (!rsp_vib_ff && (rsp_score_ff == '0)))
      else $error("calibration word carries a score or vibration flag");

   a_vib_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vib_ff) |-> (rsp_score_ff != '0))
      else $error("vibration flagged with a zero score");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the output stage");

endmodule

`default_nettype wire
